@@ sv/frame_vlan_strip_tcp_filter_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the frame VLAN strip and TCP filter unit
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef FRAME_VLAN_STRIP_TCP_FILTER_UNIT_MACROS_SVH
`define FRAME_VLAN_STRIP_TCP_FILTER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FVST_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FVST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/fvst_pkg.sv @@
// ----------------------------------------------------------------------------
// Frame VLAN strip package
// Types and constants shared by the stages of the strip and filter unit.
// ----------------------------------------------------------------------------
package fvst_pkg;

  localparam int unsigned PKT_BYTES = 2048;

  localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_TYPE_VLAN = 16'h8100;
  localparam logic [15:0] ETH_TYPE_POS  = 16'd12;
  localparam logic [15:0] ETH_HDR_BYTES = 16'd14;
  localparam logic [15:0] VLAN_HDR_END  = 16'd18;
  localparam logic [15:0] VLAN_TYPE_POS = 16'd16;
  localparam logic [15:0] MIN_FRAME     = 16'd54;
  localparam logic [7:0]  PROTO_TCP     = 8'd6;
  localparam logic [7:0]  PROTO_UDP     = 8'd17;
  localparam logic [6:0]  TCP_HDR_MIN   = 7'd20;
  localparam logic [6:0]  UDP_HDR_MIN   = 7'd8;

  // One result item as it leaves the core.
  typedef struct packed {
    logic        out_valid;
    logic [7:0]  out_byte;
    logic [10:0] out_index;
    logic        frame_end;
    logic        accepted;
    logic [11:0] kept_length;
  } fvst_result_t;

endpackage

@@ sv/fvst_if.sv @@
// ----------------------------------------------------------------------------
// Frame VLAN strip channel interfaces
// Valid/ready channels for input bytes and for result items.
// ----------------------------------------------------------------------------
interface fvst_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink (input valid, input in_byte, input last_byte, output ready);
endinterface

interface fvst_out_if;
  logic        valid;
  logic        ready;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic [10:0] out_index;
  logic        frame_end;
  logic        accepted;
  logic [11:0] kept_length;

  modport source (output valid, output out_valid, output out_byte, output out_index,
                  output frame_end, output accepted, output kept_length, input ready);
  modport sink (input valid, input out_valid, input out_byte, input out_index,
                input frame_end, input accepted, input kept_length, output ready);
endinterface

@@ sv/fvst_in_stage.sv @@
// ----------------------------------------------------------------------------
// Frame VLAN strip input stage
// Registers one input request; refills in the cycle the held one moves on.
// ----------------------------------------------------------------------------
module fvst_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  fvst_in_if.sink    in_i,
  input  logic       take_i,
  output logic       vld_o,
  output logic [7:0] byte_o,
  output logic       last_o
);

  logic       vld_q, vld_d;
  logic [7:0] byte_q;
  logic       last_q;
  logic       load;

  assign in_i.ready = !vld_q || take_i;
  assign load       = in_i.valid && in_i.ready;

  always_comb begin
    vld_d = vld_q;
    if (load) begin
      vld_d = 1'b1;
    end else if (take_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= in_i.in_byte;
      last_q <= in_i.last_byte;
    end
  end

  assign vld_o  = vld_q;
  assign byte_o = byte_q;
  assign last_o = last_q;

endmodule

@@ sv/fvst_core.sv @@
// ----------------------------------------------------------------------------
// Frame VLAN strip core
// Per-frame parse state and the combinational rewrite and verdict logic.
// ----------------------------------------------------------------------------
module fvst_core import fvst_pkg::*; #(
  parameter int unsigned PktBytes = PKT_BYTES
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         step_i,
  input  logic [7:0]   in_byte_i,
  input  logic         last_byte_i,
  output fvst_result_t res_o,
  output logic         produce_o
);

`include "frame_vlan_strip_tcp_filter_unit_macros.svh"

  localparam int unsigned OutCntW = $clog2(PktBytes + 1);
  localparam logic [OutCntW-1:0] PktMax = OutCntW'(PktBytes);
  localparam logic [16:0] PktLim = 17'(PktBytes);

  logic [15:0] cnt_q, cnt_d;
  logic [15:0] outer_q, outer_d;
  logic [15:0] inner_q, inner_d;
  logic        tagged_q, tagged_d;
  logic [3:0]  ihl_q, ihl_d;
  logic [15:0] total_q, total_d;
  logic [7:0]  proto_q, proto_d;
  logic [3:0]  tcp_q, tcp_d;
  logic [2:0]  flags_q, flags_d;
  logic [OutCntW-1:0] ocnt_q, ocnt_d;

  logic        emit;
  logic [7:0]  ob;
  logic [15:0] oi;
  logic [15:0] ip_start;
  logic [15:0] p;
  logic [5:0]  ihl_bytes;
  logic [6:0]  tcp_pos;
  logic [6:0]  tcp_need;
  logic [6:0]  udp_need;
  logic        type_ok;
  logic        verdict;
  logic [16:0] lim;
  logic [16:0] ocnt_ext;
  logic [16:0] kept;

  always_comb begin
    cnt_d    = cnt_q;
    outer_d  = outer_q;
    inner_d  = inner_q;
    tagged_d = tagged_q;
    ihl_d    = ihl_q;
    total_d  = total_q;
    proto_d  = proto_q;
    tcp_d    = tcp_q;
    flags_d  = flags_q;
    emit     = 1'b0;
    ob       = 8'h00;
    oi       = 16'd0;
    ip_start = tagged_q ? VLAN_HDR_END : ETH_HDR_BYTES;
    p        = cnt_q - ip_start;
    ihl_bytes = '0;
    tcp_pos  = '0;

    priority if (cnt_q < ETH_TYPE_POS) begin
      emit = 1'b1;
      ob   = in_byte_i;
      oi   = cnt_q;
    end else if (cnt_q == ETH_TYPE_POS) begin
      outer_d = {in_byte_i, 8'h00};
      emit    = 1'b1;
      ob      = ETH_TYPE_IPV4[15:8];
      oi      = ETH_TYPE_POS;
    end else if (cnt_q == ETH_TYPE_POS + 16'd1) begin
      outer_d  = {outer_q[15:8], in_byte_i};
      tagged_d = ({outer_q[15:8], in_byte_i} == ETH_TYPE_VLAN);
      emit     = 1'b1;
      ob       = ETH_TYPE_IPV4[7:0];
      oi       = ETH_TYPE_POS + 16'd1;
    end else if (tagged_q && cnt_q < VLAN_HDR_END) begin
      // Tag bytes are swallowed; only the inner ethertype is kept.
      if (cnt_q == VLAN_TYPE_POS) begin
        inner_d = {in_byte_i, 8'h00};
      end else if (cnt_q == VLAN_TYPE_POS + 16'd1) begin
        inner_d = {inner_q[15:8], in_byte_i};
      end
    end else begin
      if (p == 16'd0) begin
        ihl_d = in_byte_i[3:0];
      end else if (p == 16'd2) begin
        total_d = {in_byte_i, total_q[7:0]};
      end else if (p == 16'd3) begin
        total_d = {total_q[15:8], in_byte_i};
      end else if (p == 16'd9) begin
        proto_d = in_byte_i;
      end
      // TCP fields sit at IP offset 4*IHL, whatever the IHL value.
      ihl_bytes = {ihl_d, 2'b00};
      tcp_pos   = 7'(ihl_bytes) + 7'd12;
      if (p == 16'(tcp_pos)) begin
        tcp_d = in_byte_i[7:4];
      end else if (p == 16'(tcp_pos) + 16'd1) begin
        flags_d = in_byte_i[2:0];
      end
      ob   = in_byte_i;
      oi   = p + ETH_HDR_BYTES;
      emit = (p < 16'd3) || (p < total_d);
    end

    if (emit && ({1'b0, oi} >= PktLim)) begin
      emit = 1'b0;
    end
    if (!emit) begin
      ob = 8'h00;
      oi = 16'd0;
    end

    ocnt_d = ocnt_q;
    if (emit && ocnt_q < PktMax) begin
      ocnt_d = ocnt_q + OutCntW'(1);
    end
    if (cnt_q != 16'hFFFF) begin
      cnt_d = cnt_q + 16'd1;
    end
  end

  // Verdict on the state as it stands after this byte.
  logic [5:0] jd_ihl_bytes;
  assign jd_ihl_bytes = {ihl_d, 2'b00};
  assign tcp_need = 7'(ip_start) + 7'(jd_ihl_bytes) + TCP_HDR_MIN;
  assign udp_need = 7'(ip_start) + 7'(jd_ihl_bytes) + UDP_HDR_MIN;
  assign type_ok  = (outer_d == ETH_TYPE_VLAN) ? (inner_d == ETH_TYPE_IPV4)
                                               : (outer_d == ETH_TYPE_IPV4);

  always_comb begin
    verdict = 1'b1;
    priority if (cnt_d < MIN_FRAME) begin
      verdict = 1'b0;
    end else if (!type_ok) begin
      verdict = 1'b0;
    end else if (proto_d == PROTO_TCP) begin
      if (cnt_d < 16'(tcp_need)) begin
        verdict = 1'b0;
      end else if ((total_d == 16'(jd_ihl_bytes) + 16'({tcp_d, 2'b00})) &&
                   (flags_d == 3'd0)) begin
        verdict = 1'b0;
      end
    end else if (proto_d == PROTO_UDP) begin
      if (cnt_d < 16'(udp_need)) begin
        verdict = 1'b0;
      end
    end else begin
      verdict = 1'b1;
    end
  end

  assign lim      = 17'(total_d) + 17'd14;
  assign ocnt_ext = 17'(ocnt_d);
  assign kept     = (ocnt_ext < lim) ? ocnt_ext : lim;

  always_comb begin
    res_o.out_valid   = emit;
    res_o.out_byte    = ob;
    res_o.out_index   = oi[10:0];
    res_o.frame_end   = last_byte_i;
    res_o.accepted    = last_byte_i && verdict;
    res_o.kept_length = (last_byte_i && verdict) ? kept[11:0] : 12'd0;
  end

  assign produce_o = emit || last_byte_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      outer_q  <= '0;
      inner_q  <= '0;
      tagged_q <= 1'b0;
      ihl_q    <= '0;
      total_q  <= '0;
      proto_q  <= '0;
      tcp_q    <= '0;
      flags_q  <= '0;
      ocnt_q   <= '0;
    end else if (step_i) begin
      if (last_byte_i) begin
        cnt_q    <= '0;
        outer_q  <= '0;
        inner_q  <= '0;
        tagged_q <= 1'b0;
        ihl_q    <= '0;
        total_q  <= '0;
        proto_q  <= '0;
        tcp_q    <= '0;
        flags_q  <= '0;
        ocnt_q   <= '0;
      end else begin
        cnt_q    <= cnt_d;
        outer_q  <= outer_d;
        inner_q  <= inner_d;
        tagged_q <= tagged_d;
        ihl_q    <= ihl_d;
        total_q  <= total_d;
        proto_q  <= proto_d;
        tcp_q    <= tcp_d;
        flags_q  <= flags_d;
        ocnt_q   <= ocnt_d;
      end
    end
  end

  `FVST_ASSERT_NEXT(a_clear_after_last, step_i && last_byte_i, cnt_q == 16'd0 && ocnt_q == '0, "frame state not cleared after last byte")
  `FVST_ASSERT_SAME(a_idle_payload_zero, step_i && !res_o.out_valid, res_o.out_byte == 8'h00 && res_o.out_index == 11'd0, "payload not zero without output byte")
  `FVST_ASSERT_SAME(a_verdict_at_end, step_i && !res_o.frame_end, !res_o.accepted && res_o.kept_length == 12'd0, "verdict outside frame end")
  `FVST_ASSERT_SAME(a_out_count_bound, 1'b1, ocnt_q <= PktMax, "output count beyond bound")

endmodule

@@ sv/fvst_out_stage.sv @@
// ----------------------------------------------------------------------------
// Frame VLAN strip result stage
// Result register that holds one result request until the sink takes it.
// ----------------------------------------------------------------------------
module fvst_out_stage import fvst_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         load_i,
  input  fvst_result_t res_i,
  output logic         free_o,
  fvst_out_if.source   out_o
);

  logic         vld_q, vld_d;
  fvst_result_t res_q;

  assign free_o = !vld_q || out_o.ready;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (out_o.ready) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid       = vld_q;
  assign out_o.out_valid   = res_q.out_valid;
  assign out_o.out_byte    = res_q.out_byte;
  assign out_o.out_index   = res_q.out_index;
  assign out_o.frame_end   = res_q.frame_end;
  assign out_o.accepted    = res_q.accepted;
  assign out_o.kept_length = res_q.kept_length;

endmodule

@@ sv/frame_vlan_strip_tcp_filter_unit.sv @@
// ----------------------------------------------------------------------------
// Frame VLAN strip and TCP filter unit
// Rewrites a captured Ethernet frame byte by byte, drops an 802.1Q tag, forces
// the ethertype to IPv4 and gives a keep or discard verdict on the last byte.
// ----------------------------------------------------------------------------
//  Channel | Direction | Payload                                  | Request
//  in_i    | sink      | in_byte, last_byte                       | one frame byte
//  out_o   | source    | out_valid, out_byte, out_index,          | one result
//          |           | frame_end, accepted, kept_length         |
//
// One byte is accepted per cycle unless a byte that gives a result waits for room in
// the result register; a result passes from the input register through the rewrite
// and verdict logic into the result register.
// Bytes that are not last and give no result, such as tag bytes, move on even while
// the result register is stalled; all other bytes wait for room in that register.
// Reset is asynchronous and clears the channel valids and the parse state.
// ----------------------------------------------------------------------------
module frame_vlan_strip_tcp_filter_unit import fvst_pkg::*; #(
  parameter int unsigned PktBytes = PKT_BYTES
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fvst_in_if.sink   in_i,
  fvst_out_if.source out_o
);

  // Byte held in the input register, waiting for the core.
  logic         stg_vld;
  logic [7:0]   stg_byte;
  logic         stg_last;

  // The core works on the held byte in the cycle that it is taken.
  logic         take;
  logic         produce;
  logic         out_free;
  fvst_result_t res;

  // A byte that yields a result needs room downstream; one that yields
  // nothing can always be taken.
  assign take = stg_vld && (!produce || out_free);

  fvst_in_stage u_in_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .take_i (take),
    .vld_o  (stg_vld),
    .byte_o (stg_byte),
    .last_o (stg_last)
  );

  fvst_core #(
    .PktBytes (PktBytes)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (take),
    .in_byte_i   (stg_byte),
    .last_byte_i (stg_last),
    .res_o       (res),
    .produce_o   (produce)
  );

  fvst_out_stage u_out_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (take && produce),
    .res_i  (res),
    .free_o (out_free),
    .out_o  (out_o)
  );

endmodule
